@@ hdl/mte_pkg.sv @@
// Shared types and constants for the markup tag extractor.
// No dependencies; the files that use it refer to it by scoped names.
package mte_pkg;

    // Special bytes of the markup stream
    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Result kinds
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_TAG   = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // What an accepted byte causes
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_TEXT,
        ACT_EMPTY,
        ACT_BURST
    } action_t;

    // Source of the next output register load
    typedef enum logic [1:0] {
        LD_NONE,
        LD_INPUT,
        LD_PEND,
        LD_RAM
    } load_t;

    typedef struct packed {
        logic  accept;   // transaction taken on the input channel
        load_t load;     // output register load source
        logic  rd_en;    // issue a tag store read
        logic  rd_next;  // read the entry after the one being loaded
    } cmd_t;

    typedef struct packed {
        action_t action;     // effect of the byte on s_in_byte
        logic    out_free;   // output register can take a result this cycle
        logic    burst_last; // entry being loaded is the final stored byte
    } status_t;

endpackage

@@ hdl/mte_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/mte_datapath.sv @@
// Datapath: mode and tag length registers, tag store, pending result and
// output register. Depends on mte_pkg and mte_ram.
module mte_datapath #(
    parameter int TAG_DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [7:0]       s_in_byte,
    input  mte_pkg::cmd_t    cmd,
    output mte_pkg::status_t status,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic [1:0]       m_kind,
    output logic             m_last_of_run
);

    localparam int IW = $clog2(TAG_DEPTH);
    localparam int LW = $clog2(TAG_DEPTH + 1);
    localparam logic [LW-1:0] LEN_FULL = LW'(TAG_DEPTH);
    localparam logic [LW-1:0] LEN_ONE  = LW'(1);

    typedef enum logic [1:0] {
        MODE_OUTSIDE,
        MODE_INSIDE,
        MODE_DISCARD
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [LW-1:0]    len_reg, len_next;
    logic [LW-1:0]    cnt_reg;
    logic [7:0]       pend_byte_reg;
    logic [1:0]       pend_kind_reg;
    logic             m_valid_reg;
    logic [7:0]       m_out_byte_reg;
    logic [1:0]       m_kind_reg;
    logic             m_last_reg;

    mte_pkg::action_t action;
    logic             store_byte;
    logic             is_crlf;
    logic             out_free;
    logic             burst_last;
    logic [LW-1:0]    cnt_inc;
    logic [IW-1:0]    rd_addr;
    logic [7:0]       rd_data;
    logic [7:0]       res_byte;
    logic [1:0]       res_kind;

    assign is_crlf = (s_in_byte == mte_pkg::CH_CR) || (s_in_byte == mte_pkg::CH_LF);

    always_comb begin
        action     = mte_pkg::ACT_NONE;
        mode_next  = mode_reg;
        len_next   = len_reg;
        store_byte = 1'b0;
        if (mode_reg == MODE_INSIDE) begin
            if (!is_crlf) begin
                if (s_in_byte == mte_pkg::CH_CLOSE) begin
                    // keep the length: the burst reads it and clears it at the end
                    mode_next = MODE_OUTSIDE;
                    action    = (len_reg == '0) ? mte_pkg::ACT_EMPTY : mte_pkg::ACT_BURST;
                end else if (len_reg == LEN_FULL) begin
                    // overflow: drop the tag
                    mode_next = MODE_DISCARD;
                    len_next  = '0;
                end else if (s_in_byte != mte_pkg::CH_NUL) begin
                    store_byte = 1'b1;
                    len_next   = len_reg + LEN_ONE;
                end
            end
        end else begin
            if (s_in_byte == mte_pkg::CH_OPEN) begin
                mode_next = MODE_INSIDE;
                len_next  = '0;
            end else if (mode_reg == MODE_OUTSIDE && s_in_byte != mte_pkg::CH_NUL) begin
                action = mte_pkg::ACT_TEXT;
            end
        end
    end

    assign res_byte = (action == mte_pkg::ACT_EMPTY) ? 8'h00 : s_in_byte;
    assign res_kind = (action == mte_pkg::ACT_EMPTY) ? mte_pkg::KIND_EMPTY
                                                     : mte_pkg::KIND_TEXT;

    assign cnt_inc    = cnt_reg + LEN_ONE;
    assign burst_last = (cnt_inc == len_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign rd_addr    = cmd.rd_next ? IW'(cnt_inc) : cnt_reg[IW-1:0];

    mte_ram #(
        .WIDTH(8),
        .DEPTH(TAG_DEPTH)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (cmd.accept && store_byte),
        .wr_addr(len_reg[IW-1:0]),
        .wr_data(s_in_byte),
        .rd_en  (cmd.rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_OUTSIDE;
            len_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
            end
            if (cmd.load == mte_pkg::LD_RAM) begin
                if (burst_last) begin
                    len_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_inc;
                end
            end
            if (cmd.load != mte_pkg::LD_NONE) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pend_byte_reg <= res_byte;
            pend_kind_reg <= res_kind;
        end
        unique case (cmd.load)
            mte_pkg::LD_INPUT: begin
                m_out_byte_reg <= res_byte;
                m_kind_reg     <= res_kind;
                m_last_reg     <= 1'b1;
            end
            mte_pkg::LD_PEND: begin
                m_out_byte_reg <= pend_byte_reg;
                m_kind_reg     <= pend_kind_reg;
                m_last_reg     <= 1'b1;
            end
            mte_pkg::LD_RAM: begin
                m_out_byte_reg <= rd_data;
                m_kind_reg     <= mte_pkg::KIND_TAG;
                m_last_reg     <= burst_last;
            end
            default: begin
                // hold
            end
        endcase
    end

    assign status.action     = action;
    assign status.out_free   = out_free;
    assign status.burst_last = burst_last;

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_out_byte_reg;
    assign m_kind        = m_kind_reg;
    assign m_last_of_run = m_last_reg;

endmodule

@@ hdl/mte_ctrl.sv @@
// Controller: accepts bytes, hands text and empty-tag results to the output
// register and sequences tag store reads at a '>'. Depends on mte_pkg.
module mte_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mte_pkg::status_t status,
    output mte_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PEND,
        S_READ,
        S_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    always_comb begin
        state_next  = state_reg;
        cmd.accept  = 1'b0;
        cmd.load    = mte_pkg::LD_NONE;
        cmd.rd_en   = 1'b0;
        cmd.rd_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.accept = 1'b1;
                    unique case (status.action)
                        mte_pkg::ACT_TEXT, mte_pkg::ACT_EMPTY: begin
                            if (status.out_free) begin
                                cmd.load = mte_pkg::LD_INPUT;
                            end else begin
                                state_next = S_PEND;
                            end
                        end
                        mte_pkg::ACT_BURST: state_next = S_READ;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_PEND: begin
                if (status.out_free) begin
                    cmd.load   = mte_pkg::LD_PEND;
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (status.out_free) begin
                    cmd.load = mte_pkg::LD_RAM;
                    if (status.burst_last) begin
                        state_next = S_IDLE;
                    end else begin
                        // fetch the following entry while this one moves out
                        cmd.rd_en   = 1'b1;
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

@@ hdl/markup_tag_extractor_top.sv @@
// Markup tag extractor: splits a byte stream into text bytes and tag contents.
// Input channel s_ (one byte per transaction), result channel m_ (byte, kind,
// last flag). Both use valid/ready; a transaction moves when both are high.
// Text outside a tag leaves as one kind 0 result, loaded into the output
// register when the byte is accepted if that register is free. Tag bytes are
// written into a TAG_DEPTH entry store, one per cycle, and each is read back
// once. A closing '>' starts a burst: S_READ issues the first store read and
// S_LOAD moves the read data out, then one tag byte per cycle while the output
// register is free (kind 1, last set on the final byte) from the registered
// store read port. An empty tag gives one kind 2 result. Bytes that produce
// nothing, and results that find the output register free, leave s_ready
// high; a result that finds it occupied waits in the pending register.
// s_ready drops while a burst is read out or a result waits for space.
// A stalled receiver holds the output register; the block keeps accepting
// bytes that produce no result and holds at most one text result aside.
// Reset (aresetn low, synchronous) returns to text mode with an empty store
// and no result pending; no clearing pass is needed.
// Depends on mte_pkg, mte_ctrl, mte_datapath and mte_ram.
module markup_tag_extractor_top #(
    parameter int TAG_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_kind,
    output logic       m_last_of_run
);

    mte_pkg::cmd_t    cmd;
    mte_pkg::status_t status;

    mte_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    mte_datapath #(
        .TAG_DEPTH(TAG_DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_in_byte    (s_in_byte),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_kind       (m_kind),
        .m_last_of_run(m_last_of_run)
    );

endmodule

@@ hdl/mte_checker.sv @@
// Port-level checks for markup_tag_extractor_top, attached by bind.
// Depends on mte_pkg.
module mte_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic [1:0] m_kind,
    input logic       m_last_of_run
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_kind)
                                && $stable(m_last_of_run))
        else $error("stalled result changed");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("handshake active after reset");

    a_text_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == mte_pkg::KIND_TEXT |-> m_last_of_run)
        else $error("text result not marked last");

    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == mte_pkg::KIND_EMPTY |-> m_last_of_run && m_out_byte == 8'h00)
        else $error("malformed empty-tag result");

    a_kind_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kind == mte_pkg::KIND_TEXT || m_kind == mte_pkg::KIND_TAG
                    || m_kind == mte_pkg::KIND_EMPTY)
        else $error("unknown result kind");

endmodule

bind markup_tag_extractor_top mte_checker u_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_byte   (m_out_byte),
    .m_kind       (m_kind),
    .m_last_of_run(m_last_of_run)
);
